[rtl/core/banker_safe_grant_engine_defines.svh]
// Assertion macros used by the grant engine top level.
`ifndef BANKER_SAFE_GRANT_ENGINE_DEFINES_SVH
`define BANKER_SAFE_GRANT_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BSGE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define BSGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bsge_pkg.sv]
// Shared constants, codes and result type of the grant engine.
package bsge_pkg;

	localparam int MAX_THREADS_DEF   = 8;
	localparam int MAX_RESOURCES_DEF = 8;
	localparam int AMOUNT_BITS_DEF   = 8;

	localparam int CMD_QUEUE_DEPTH = 2;
	localparam int RES_QUEUE_DEPTH = 4;

	localparam logic [1:0] REQ_ENTRY = 2'd0;
	localparam logic [1:0] REQ_AVAIL = 2'd1;
	localparam logic [1:0] REQ_ELEM  = 2'd2;

	localparam logic [2:0] K_BAD        = 3'd0;
	localparam logic [2:0] K_ENTRY      = 3'd1;
	localparam logic [2:0] K_AVAIL      = 3'd2;
	localparam logic [2:0] K_ELEM       = 3'd3;
	localparam logic [2:0] K_FINAL      = 3'd4;
	localparam logic [2:0] K_FINAL_OVER = 3'd5;

	localparam logic [2:0] ST_ACCEPT  = 3'd0;
	localparam logic [2:0] ST_GRANT   = 3'd1;
	localparam logic [2:0] ST_OVER    = 3'd2;
	localparam logic [2:0] ST_UNAVAIL = 3'd3;
	localparam logic [2:0] ST_UNSAFE  = 3'd4;
	localparam logic [2:0] ST_BAD     = 3'd5;

	localparam logic CFG_THREADS   = 1'b0;
	localparam logic CFG_RESOURCES = 1'b1;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] seq_thread;
		logic       last;
	} res_t;

endpackage

[rtl/core/bsge_queue.sv]
// Small first-in first-out queue between the engine stages.
module bsge_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push & ~full;
	assign pop_ok  = pop & ~empty;
	assign rdata   = store_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop_ok) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			store_q[wp_q] <= wdata;
		end
	end

endmodule

[rtl/core/bsge_front.sv]
// Front stage: classifies an incoming transaction into a command.
module bsge_front #(
	parameter int MAX_THREADS   = bsge_pkg::MAX_THREADS_DEF,
	parameter int MAX_RESOURCES = bsge_pkg::MAX_RESOURCES_DEF,
	parameter int AMOUNT_BITS   = bsge_pkg::AMOUNT_BITS_DEF,
	localparam int TI    = $clog2(MAX_THREADS),
	localparam int TC    = $clog2(MAX_THREADS + 1),
	localparam int RI    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
	localparam int RC    = $clog2(MAX_RESOURCES + 1),
	localparam int AW    = AMOUNT_BITS,
	localparam int CMD_W = 3 + TI + RI + 2 * AW + 1
) (
	input  logic [1:0]       req_type,
	input  logic [2:0]       thread_id,
	input  logic [2:0]       resource_id,
	input  logic [7:0]       amount,
	input  logic [7:0]       max_claim,
	input  logic             is_last,
	input  logic [TC-1:0]    nt,
	input  logic [RC-1:0]    nr,
	output logic [CMD_W-1:0] cmd
);

	logic [31:0]   tid_w;
	logic [31:0]   rid_w;
	logic [15:0]   amt_w;
	logic [15:0]   mx_w;
	logic [AW-1:0] amt;
	logic [AW-1:0] mx;
	logic          tid_ok;
	logic          rid_ok;
	logic [2:0]    kind;

	assign tid_w  = 32'(thread_id);
	assign rid_w  = 32'(resource_id);
	assign amt_w  = 16'(amount);
	assign mx_w   = 16'(max_claim);
	assign amt    = amt_w[AW-1:0];
	assign mx     = mx_w[AW-1:0];
	assign tid_ok = tid_w < 32'(nt);
	assign rid_ok = rid_w < 32'(nr);

	always_comb begin
		case (req_type)
			bsge_pkg::REQ_ENTRY: begin
				kind = (tid_ok && rid_ok && mx >= amt) ? bsge_pkg::K_ENTRY : bsge_pkg::K_BAD;
			end
			bsge_pkg::REQ_AVAIL: begin
				kind = rid_ok ? bsge_pkg::K_AVAIL : bsge_pkg::K_BAD;
			end
			bsge_pkg::REQ_ELEM: begin
				if (!is_last) begin
					kind = bsge_pkg::K_ELEM;
				end else begin
					kind = tid_ok ? bsge_pkg::K_FINAL : bsge_pkg::K_FINAL_OVER;
				end
			end
			default: begin
				kind = bsge_pkg::K_BAD;
			end
		endcase
	end

	assign cmd = {kind, tid_w[TI-1:0], rid_w[RI-1:0], amt, mx - amt, rid_ok};

endmodule

[rtl/core/bsge_back.sv]
// Back stage: table memories, request checks, safety scan and result sequencing.
module bsge_back #(
	parameter int MAX_THREADS   = bsge_pkg::MAX_THREADS_DEF,
	parameter int MAX_RESOURCES = bsge_pkg::MAX_RESOURCES_DEF,
	parameter int AMOUNT_BITS   = bsge_pkg::AMOUNT_BITS_DEF,
	localparam int TI    = $clog2(MAX_THREADS),
	localparam int TC    = $clog2(MAX_THREADS + 1),
	localparam int RI    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
	localparam int RC    = $clog2(MAX_RESOURCES + 1),
	localparam int AW    = AMOUNT_BITS,
	localparam int WW    = AW + TC,
	localparam int CMD_W = 3 + TI + RI + 2 * AW + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [TC-1:0]    nt,
	input  logic [RC-1:0]    nr,
	input  logic             cmd_empty,
	input  logic [CMD_W-1:0] cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output bsge_pkg::res_t   res,
	output logic             clr_busy
);

	localparam logic [4:0] S_CLEAR    = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_EMIT     = 5'd2;
	localparam logic [4:0] S_CHK_RD   = 5'd3;
	localparam logic [4:0] S_CHK_CMP  = 5'd4;
	localparam logic [4:0] S_APP_RD   = 5'd5;
	localparam logic [4:0] S_APP_WR   = 5'd6;
	localparam logic [4:0] S_INIT     = 5'd7;
	localparam logic [4:0] S_SC_TH    = 5'd8;
	localparam logic [4:0] S_SC_RD    = 5'd9;
	localparam logic [4:0] S_SC_CMP   = 5'd10;
	localparam logic [4:0] S_ADD_RD   = 5'd11;
	localparam logic [4:0] S_ADD_WR   = 5'd12;
	localparam logic [4:0] S_PASS_END = 5'd13;
	localparam logic [4:0] S_GRANT    = 5'd14;
	localparam logic [4:0] S_RB_RD    = 5'd15;
	localparam logic [4:0] S_RB_WR    = 5'd16;

	logic [2:0]    c_kind;
	logic [TI-1:0] c_tid;
	logic [RI-1:0] c_rid;
	logic [AW-1:0] c_amt;
	logic [AW-1:0] c_nd;
	logic          c_wr;

	logic [AW-1:0] alloc_mem [MAX_THREADS][MAX_RESOURCES];
	logic [AW-1:0] need_mem  [MAX_THREADS][MAX_RESOURCES];
	logic [AW-1:0] alloc_rd_q;
	logic [AW-1:0] need_rd_q;

	logic [AW-1:0]          avail_q [MAX_RESOURCES];
	logic [AW-1:0]          buf_q   [MAX_RESOURCES];
	logic [WW-1:0]          work_q  [MAX_RESOURCES];
	logic [TI-1:0]          order_q [MAX_THREADS];
	logic [MAX_THREADS-1:0] fin_q;

	logic [4:0]    state_q;
	logic [TI-1:0] tid_q;
	logic [TC-1:0] t_q;
	logic [TC-1:0] p_q;
	logic [TC-1:0] done_q;
	logic [TC-1:0] k_q;
	logic [RC-1:0] r_q;
	logic          prog_q;
	logic          over_q;
	logic          unav_q;
	logic [2:0]    stat_q;

	logic [RI-1:0] r_i;
	logic [TI-1:0] t_i;
	logic [TI-1:0] k_i;
	logic          r_last;
	logic          t_last;
	logic          k_last;
	logic          clr_r_last;
	logic          clr_t_last;
	logic [AW-1:0] b_cur;
	logic          over_any;
	logic          unav_any;
	logic          need_gt;

	logic          mem_we;
	logic [TI-1:0] mem_wt;
	logic [RI-1:0] mem_wr;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_wn;
	logic [TI-1:0] rd_t;
	logic          buf_we;
	logic          buf_clr;
	logic          work_init;
	logic          work_add;
	logic          order_we;
	logic          res_valid;

	assign {c_kind, c_tid, c_rid, c_amt, c_nd, c_wr} = cmd;

	assign r_i        = r_q[RI-1:0];
	assign t_i        = t_q[TI-1:0];
	assign k_i        = k_q[TI-1:0];
	assign r_last     = (r_q + RC'(1)) == nr;
	assign t_last     = (t_q + TC'(1)) == nt;
	assign k_last     = (k_q + TC'(1)) == nt;
	assign clr_r_last = (r_q == RC'(MAX_RESOURCES - 1));
	assign clr_t_last = (t_q == TC'(MAX_THREADS - 1));
	assign b_cur      = buf_q[r_i];
	assign over_any   = over_q | (b_cur > need_rd_q);
	assign unav_any   = unav_q | (b_cur > avail_q[r_i]);
	assign need_gt    = WW'(need_rd_q) > work_q[r_i];
	assign clr_busy   = (state_q == S_CLEAR);
	assign order_we   = (state_q == S_ADD_WR) && r_last;
	assign res_push   = res_valid & ~res_full;
	assign rd_t       = (state_q == S_SC_RD || state_q == S_ADD_RD) ? t_i : tid_q;

	always_comb begin
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_wt    = tid_q;
		mem_wr    = r_i;
		mem_wa    = '0;
		mem_wn    = '0;
		buf_we    = 1'b0;
		buf_clr   = 1'b0;
		work_init = 1'b0;
		work_add  = 1'b0;
		res_valid = 1'b0;
		res       = '{status: stat_q, seq_thread: 3'd0, last: 1'b1};
		case (state_q)
			S_CLEAR: begin
				mem_we  = 1'b1;
				mem_wt  = t_i;
				buf_clr = 1'b1;
			end
			S_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (c_kind == bsge_pkg::K_ENTRY) begin
						mem_we = 1'b1;
						mem_wt = c_tid;
						mem_wr = c_rid;
						mem_wa = c_amt;
						mem_wn = c_nd;
					end
					if ((c_kind == bsge_pkg::K_ELEM || c_kind == bsge_pkg::K_FINAL) && c_wr) begin
						buf_we = 1'b1;
					end
					if (c_kind == bsge_pkg::K_FINAL_OVER) begin
						buf_clr = 1'b1;
					end
				end
			end
			S_EMIT: begin
				res_valid = 1'b1;
			end
			S_CHK_CMP: begin
				buf_clr = r_last & (over_any | unav_any);
			end
			S_APP_WR: begin
				mem_we = 1'b1;
				mem_wa = alloc_rd_q + b_cur;
				mem_wn = need_rd_q - b_cur;
			end
			S_INIT: begin
				work_init = 1'b1;
			end
			S_ADD_WR: begin
				work_add = 1'b1;
			end
			S_PASS_END: begin
				buf_clr = (done_q == nt);
			end
			S_GRANT: begin
				res_valid = 1'b1;
				res       = '{status: bsge_pkg::ST_GRANT, seq_thread: 3'(order_q[k_i]),
					last: k_last};
			end
			S_RB_WR: begin
				mem_we  = 1'b1;
				mem_wa  = alloc_rd_q - b_cur;
				mem_wn  = need_rd_q + b_cur;
				buf_clr = r_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			alloc_mem[mem_wt][mem_wr] <= mem_wa;
			need_mem[mem_wt][mem_wr]  <= mem_wn;
		end
		alloc_rd_q <= alloc_mem[rd_t][r_i];
		need_rd_q  <= need_mem[rd_t][r_i];
	end

	always_ff @(posedge clk) begin
		if (buf_clr) begin
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				buf_q[i] <= '0;
			end
		end else if (buf_we) begin
			buf_q[c_rid] <= c_amt;
		end
	end

	always_ff @(posedge clk) begin
		if (work_init) begin
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				work_q[i] <= WW'(avail_q[i]);
			end
		end else if (work_add) begin
			work_q[r_i] <= work_q[r_i] + WW'(alloc_rd_q);
		end
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_q[done_q[TI-1:0]] <= t_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tid_q   <= '0;
			t_q     <= '0;
			p_q     <= '0;
			done_q  <= '0;
			k_q     <= '0;
			r_q     <= '0;
			prog_q  <= 1'b0;
			over_q  <= 1'b0;
			unav_q  <= 1'b0;
			stat_q  <= bsge_pkg::ST_ACCEPT;
			fin_q   <= '0;
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				avail_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_r_last) begin
						r_q <= '0;
						if (clr_t_last) begin
							t_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							t_q <= t_q + TC'(1);
						end
					end else begin
						r_q <= r_q + RC'(1);
					end
				end
				S_IDLE: begin
					if (!cmd_empty) begin
						tid_q <= c_tid;
						case (c_kind)
							bsge_pkg::K_ENTRY, bsge_pkg::K_ELEM: begin
								stat_q  <= bsge_pkg::ST_ACCEPT;
								state_q <= S_EMIT;
							end
							bsge_pkg::K_AVAIL: begin
								avail_q[c_rid] <= c_amt;
								stat_q         <= bsge_pkg::ST_ACCEPT;
								state_q        <= S_EMIT;
							end
							bsge_pkg::K_FINAL: begin
								r_q     <= '0;
								over_q  <= 1'b0;
								unav_q  <= 1'b0;
								state_q <= S_CHK_RD;
							end
							bsge_pkg::K_FINAL_OVER: begin
								stat_q  <= bsge_pkg::ST_OVER;
								state_q <= S_EMIT;
							end
							default: begin
								stat_q  <= bsge_pkg::ST_BAD;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_EMIT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				S_CHK_RD: begin
					state_q <= S_CHK_CMP;
				end
				S_CHK_CMP: begin
					over_q <= over_any;
					unav_q <= unav_any;
					if (r_last) begin
						r_q <= '0;
						if (over_any) begin
							stat_q  <= bsge_pkg::ST_OVER;
							state_q <= S_EMIT;
						end else if (unav_any) begin
							stat_q  <= bsge_pkg::ST_UNAVAIL;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_APP_RD;
						end
					end else begin
						r_q     <= r_q + RC'(1);
						state_q <= S_CHK_RD;
					end
				end
				S_APP_RD: begin
					state_q <= S_APP_WR;
				end
				S_APP_WR: begin
					avail_q[r_i] <= avail_q[r_i] - b_cur;
					if (r_last) begin
						r_q     <= '0;
						state_q <= S_INIT;
					end else begin
						r_q     <= r_q + RC'(1);
						state_q <= S_APP_RD;
					end
				end
				S_INIT: begin
					fin_q   <= '0;
					t_q     <= '0;
					p_q     <= '0;
					done_q  <= '0;
					prog_q  <= 1'b0;
					r_q     <= '0;
					state_q <= S_SC_TH;
				end
				S_SC_TH: begin
					if (fin_q[t_i]) begin
						if (t_last) begin
							state_q <= S_PASS_END;
						end else begin
							t_q     <= t_q + TC'(1);
							state_q <= S_SC_TH;
						end
					end else begin
						r_q     <= '0;
						state_q <= S_SC_RD;
					end
				end
				S_SC_RD: begin
					state_q <= S_SC_CMP;
				end
				S_SC_CMP: begin
					if (need_gt) begin
						if (t_last) begin
							state_q <= S_PASS_END;
						end else begin
							t_q     <= t_q + TC'(1);
							state_q <= S_SC_TH;
						end
					end else if (r_last) begin
						r_q     <= '0;
						state_q <= S_ADD_RD;
					end else begin
						r_q     <= r_q + RC'(1);
						state_q <= S_SC_RD;
					end
				end
				S_ADD_RD: begin
					state_q <= S_ADD_WR;
				end
				S_ADD_WR: begin
					if (r_last) begin
						fin_q[t_i] <= 1'b1;
						done_q     <= done_q + TC'(1);
						prog_q     <= 1'b1;
						if (t_last) begin
							state_q <= S_PASS_END;
						end else begin
							t_q     <= t_q + TC'(1);
							state_q <= S_SC_TH;
						end
					end else begin
						r_q     <= r_q + RC'(1);
						state_q <= S_ADD_RD;
					end
				end
				S_PASS_END: begin
					if (done_q == nt) begin
						k_q     <= '0;
						state_q <= S_GRANT;
					end else if (!prog_q || (p_q + TC'(1)) == nt) begin
						r_q     <= '0;
						state_q <= S_RB_RD;
					end else begin
						p_q     <= p_q + TC'(1);
						t_q     <= '0;
						prog_q  <= 1'b0;
						state_q <= S_SC_TH;
					end
				end
				S_GRANT: begin
					if (!res_full) begin
						if (k_last) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + TC'(1);
						end
					end
				end
				S_RB_RD: begin
					state_q <= S_RB_WR;
				end
				S_RB_WR: begin
					avail_q[r_i] <= avail_q[r_i] + b_cur;
					if (r_last) begin
						r_q     <= '0;
						stat_q  <= bsge_pkg::ST_UNSAFE;
						state_q <= S_EMIT;
					end else begin
						r_q     <= r_q + RC'(1);
						state_q <= S_RB_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/banker_safe_grant_engine.sv]
// Top level of the deadlock-avoidance grant engine.
//
// channel   direction  handshake            payload
// request   in         push / full          req_type thread_id resource_id amount max_claim is_last
// result    out        pop / empty          status seq_thread last
// config    in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// In the back stage, load items and non-final request elements are dequeued and then answered.
// A final element is dequeued, checked and, if it passes, applied and run through the safety scan
// (R resources, T threads), rolled back if unsafe, and then answered; the single read port of the
// tables makes each of these passes visit the table entries one by one.
// After reset a clearing pass over all MAX_THREADS*MAX_RESOURCES table entries holds full high.
// A two-entry command queue and a four-entry result queue let each side stall alone.
`include "banker_safe_grant_engine_defines.svh"

module banker_safe_grant_engine #(
	parameter int MAX_THREADS   = bsge_pkg::MAX_THREADS_DEF,
	parameter int MAX_RESOURCES = bsge_pkg::MAX_RESOURCES_DEF,
	parameter int AMOUNT_BITS   = bsge_pkg::AMOUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] req_type,
	input  logic [2:0] thread_id,
	input  logic [2:0] resource_id,
	input  logic [7:0] amount,
	input  logic [7:0] max_claim,
	input  logic       is_last,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] status,
	output logic [2:0] seq_thread,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);

	localparam int TI    = $clog2(MAX_THREADS);
	localparam int TC    = $clog2(MAX_THREADS + 1);
	localparam int RI    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int RC    = $clog2(MAX_RESOURCES + 1);
	localparam int CMD_W = 3 + TI + RI + 2 * AMOUNT_BITS + 1;
	localparam int RES_W = $bits(bsge_pkg::res_t);

	logic [TC-1:0]    nt_q;
	logic [RC-1:0]    nr_q;
	int               nt_val;
	int               nr_val;
	logic [CMD_W-1:0] cmd_in;
	logic [CMD_W-1:0] cmd_out;
	logic             cmd_full;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             clr_busy;
	logic             res_full;
	logic             res_push;
	bsge_pkg::res_t   res_in;
	bsge_pkg::res_t   res_out;
	logic [RES_W-1:0] res_rdata;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full | clr_busy;

	always_comb begin
		if (cfg_data == 4'd0) begin
			nt_val = 1;
			nr_val = 1;
		end else begin
			nt_val = (32'(cfg_data) > MAX_THREADS) ? MAX_THREADS : 32'(cfg_data);
			nr_val = (32'(cfg_data) > MAX_RESOURCES) ? MAX_RESOURCES : 32'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nt_q <= TC'(MAX_THREADS);
			nr_q <= RC'(MAX_RESOURCES);
		end else if (cfg_valid) begin
			case (cfg_index)
				bsge_pkg::CFG_THREADS: begin
					nt_q <= TC'(nt_val);
				end
				bsge_pkg::CFG_RESOURCES: begin
					nr_q <= RC'(nr_val);
				end
				default: begin
				end
			endcase
		end
	end

	bsge_front #(
		.MAX_THREADS   (MAX_THREADS),
		.MAX_RESOURCES (MAX_RESOURCES),
		.AMOUNT_BITS   (AMOUNT_BITS)
	) u_front (
		.req_type    (req_type),
		.thread_id   (thread_id),
		.resource_id (resource_id),
		.amount      (amount),
		.max_claim   (max_claim),
		.is_last     (is_last),
		.nt          (nt_q),
		.nr          (nr_q),
		.cmd         (cmd_in)
	);

	bsge_queue #(
		.WIDTH (CMD_W),
		.DEPTH (bsge_pkg::CMD_QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push & ~clr_busy),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	bsge_back #(
		.MAX_THREADS   (MAX_THREADS),
		.MAX_RESOURCES (MAX_RESOURCES),
		.AMOUNT_BITS   (AMOUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nt        (nt_q),
		.nr        (nr_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in),
		.clr_busy  (clr_busy)
	);

	bsge_queue #(
		.WIDTH (RES_W),
		.DEPTH (bsge_pkg::RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_out    = res_rdata;
	assign status     = res_out.status;
	assign seq_thread = res_out.seq_thread;
	assign last       = res_out.last;

	`BSGE_ASSERT_NOW(a_single_last, clk, arst_n, !empty && status != bsge_pkg::ST_GRANT, last, "single result transaction without last")
	`BSGE_ASSERT_NOW(a_seq_zero, clk, arst_n, !empty && status != bsge_pkg::ST_GRANT, seq_thread == 3'd0, "sequence thread set outside a grant")
	`BSGE_ASSERT_NOW(a_clear_quiet, clk, arst_n, clr_busy, empty && cmd_empty, "transaction present during table clearing")
	`BSGE_ASSERT_NEXT(a_no_reclear, clk, arst_n, push && !full, !clr_busy, "clearing pass restarted after an accepted transaction")

endmodule

[tb/banker_safe_grant_engine_tb.sv]
// Self-checking testbench of the Banker's algorithm grant engine.
module banker_safe_grant_engine_tb;

	localparam int NT = 8;
	localparam int NR = 8;
	localparam int LIMIT_CYCLES = 10000000;

	typedef struct {
		logic [1:0] rtype;
		logic [2:0] tid;
		logic [2:0] rid;
		logic [7:0] amt;
		logic [7:0] mx;
		logic       fin;
		logic       known;
		logic [2:0] want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] req_type = '0;
	logic [2:0] thread_id = '0;
	logic [2:0] resource_id = '0;
	logic [7:0] amount = '0;
	logic [7:0] max_claim = '0;
	logic       is_last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [2:0] status;
	logic [2:0] seq_thread;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic [3:0] cfg_data = '0;

	banker_safe_grant_engine dut (.*);

	always #5 clk = ~clk;

	int unsigned n_threads, n_res;
	int unsigned alloc_m[NT][NR];
	int unsigned need_m[NT][NR];
	int unsigned avail_v[NR];
	int unsigned req_buf[NR];
	bsge_pkg::res_t pending_res[$];
	int errors = 0;
	int cycles = 0;
	bit stall_rx = 1'b1;

	function automatic int unsigned clamp_cnt(logic [3:0] v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void push_res(logic [2:0] s, logic [2:0] q, logic l);
		bsge_pkg::res_t r;
		r.status = s;
		r.seq_thread = q;
		r.last = l;
		pending_res.push_back(r);
	endfunction

	function automatic int unsigned run_safety(ref logic [2:0] order[NT]);
		int unsigned work[NR];
		bit done_f[NT];
		int unsigned cnt;
		bit fits;
		cnt = 0;
		for (int r = 0; r < n_res; r++) work[r] = avail_v[r];
		for (int t = 0; t < NT; t++) done_f[t] = 1'b0;
		for (int p = 0; p < n_threads; p++)
			for (int t = 0; t < n_threads; t++) begin
				fits = !done_f[t];
				for (int r = 0; r < n_res; r++)
					if (need_m[t][r] > work[r]) fits = 1'b0;
				if (fits) begin
					for (int r = 0; r < n_res; r++) work[r] += alloc_m[t][r];
					done_f[t] = 1'b1;
					order[cnt] = 3'(t);
					cnt++;
				end
			end
		return cnt;
	endfunction

	function automatic void predict_grant(stim_row_t s);
		logic [2:0] st;
		logic [2:0] order[NT];
		if (s.rtype == bsge_pkg::REQ_ENTRY) begin
			if (s.tid >= n_threads || s.rid >= n_res || s.mx < s.amt) begin
				push_res(bsge_pkg::ST_BAD, 3'd0, 1'b1);
				return;
			end
			alloc_m[s.tid][s.rid] = s.amt;
			need_m[s.tid][s.rid] = s.mx - s.amt;
			push_res(bsge_pkg::ST_ACCEPT, 3'd0, 1'b1);
			return;
		end
		if (s.rtype == bsge_pkg::REQ_AVAIL) begin
			if (s.rid >= n_res) begin
				push_res(bsge_pkg::ST_BAD, 3'd0, 1'b1);
				return;
			end
			avail_v[s.rid] = s.amt;
			push_res(bsge_pkg::ST_ACCEPT, 3'd0, 1'b1);
			return;
		end
		if (s.rtype != bsge_pkg::REQ_ELEM) begin
			push_res(bsge_pkg::ST_BAD, 3'd0, 1'b1);
			return;
		end
		if (s.rid < n_res) req_buf[s.rid] = s.amt;
		if (!s.fin) begin
			push_res(bsge_pkg::ST_ACCEPT, 3'd0, 1'b1);
			return;
		end
		st = bsge_pkg::ST_ACCEPT;
		if (s.tid >= n_threads) st = bsge_pkg::ST_OVER;
		for (int r = 0; r < n_res; r++)
			if (st == bsge_pkg::ST_ACCEPT && req_buf[r] > need_m[s.tid][r])
				st = bsge_pkg::ST_OVER;
		for (int r = 0; r < n_res; r++)
			if (st == bsge_pkg::ST_ACCEPT && req_buf[r] > avail_v[r])
				st = bsge_pkg::ST_UNAVAIL;
		if (st == bsge_pkg::ST_ACCEPT) begin
			for (int r = 0; r < n_res; r++) begin
				alloc_m[s.tid][r] += req_buf[r];
				need_m[s.tid][r] -= req_buf[r];
				avail_v[r] -= req_buf[r];
			end
			if (run_safety(order) == n_threads) begin
				for (int r = 0; r < NR; r++) req_buf[r] = 0;
				for (int k = 0; k < n_threads; k++)
					push_res(bsge_pkg::ST_GRANT, order[k], k + 1 == n_threads);
				return;
			end
			for (int r = 0; r < n_res; r++) begin
				alloc_m[s.tid][r] -= req_buf[r];
				need_m[s.tid][r] += req_buf[r];
				avail_v[r] += req_buf[r];
			end
			st = bsge_pkg::ST_UNSAFE;
		end
		for (int r = 0; r < NR; r++) req_buf[r] = 0;
		push_res(st, 3'd0, 1'b1);
	endfunction

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, 3);
	endfunction

	function automatic stim_row_t mk_row(logic [1:0] ty, int t, int r, int a, int m, bit f,
			bit k = 0, logic [2:0] w = bsge_pkg::ST_ACCEPT);
		stim_row_t s;
		s.rtype = ty;
		s.tid = 3'(t);
		s.rid = 3'(r);
		s.amt = 8'(a);
		s.mx = 8'(m);
		s.fin = f;
		s.known = k;
		s.want = w;
		return s;
	endfunction

	task automatic send_item(stim_row_t s);
		int unsigned g;
		g = gap_len();
		if (g != 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
		push <= 1'b1;
		req_type <= s.rtype;
		thread_id <= s.tid;
		resource_id <= s.rid;
		amount <= s.amt;
		max_claim <= s.mx;
		is_last <= s.fin;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_grant(s);
		if (s.known) begin
			void'(pending_res.pop_back());
			push_res(s.want, 3'd0, 1'b1);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
		repeat (2 * NT * NT * (4 * NR + 1) + 200) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == bsge_pkg::CFG_THREADS) n_threads = clamp_cnt(val, NT);
		else n_res = clamp_cnt(val, NR);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_rx) pop <= 1'b0;
		else pop <= ($urandom_range(0, 15) == 0) ? 1'b0 : 1'b1;
	end

	always @(posedge clk) begin
		bsge_pkg::res_t e;
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("banker_safe_grant_engine_tb: FAIL");
			$finish;
		end
		if (arst_n && pop && !empty) begin
			if (pending_res.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result status %0d", status);
			end else begin
				e = pending_res.pop_front();
				if (status !== e.status || seq_thread !== e.seq_thread || last !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							e.status, e.seq_thread, e.last, status, seq_thread, last);
				end
			end
		end
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 30) == 0) stall_rx <= ~stall_rx;
		else if (stall_rx && $urandom_range(0, 3) == 0) stall_rx <= 1'b0;
	end

	task automatic random_phase(int count);
		int t;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			t = $urandom_range(0, 7);
			if (kind < 2) begin
				int a;
				a = $urandom_range(0, 20);
				send_item(mk_row(bsge_pkg::REQ_ENTRY, t, $urandom_range(0, 7), a,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : a + $urandom_range(0, 10),
					$urandom_range(0, 1)));
			end else if (kind < 3) begin
				send_item(mk_row(bsge_pkg::REQ_AVAIL, t, $urandom_range(0, 7),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
					$urandom_range(0, 255), $urandom_range(0, 1)));
			end else if (kind < 4) begin
				send_item(mk_row(2'($urandom_range(0, 3)), t, $urandom_range(0, 7),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1)));
			end else begin
				int nel;
				nel = $urandom_range(1, 4);
				for (int e = 0; e < nel; e++)
					send_item(mk_row(bsge_pkg::REQ_ELEM, t, $urandom_range(0, 7),
						($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4),
						$urandom_range(0, 255), e == nel - 1));
				i += nel - 1;
			end
		end
	endtask

	stim_row_t directed[$];

	initial begin
		n_threads = NT;
		n_res = NR;
		foreach (alloc_m[t, r]) begin
			alloc_m[t][r] = 0;
			need_m[t][r] = 0;
		end
		foreach (avail_v[r]) begin
			avail_v[r] = 0;
			req_buf[r] = 0;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed.push_back(mk_row(bsge_pkg::REQ_ELEM, 0, 0, 0, 0, 1));
		directed.push_back(mk_row(bsge_pkg::REQ_ENTRY, 7, 7, 255, 255, 0, 1, bsge_pkg::ST_ACCEPT));
		directed.push_back(mk_row(bsge_pkg::REQ_ENTRY, 3, 2, 9, 4, 1, 1, bsge_pkg::ST_BAD));
		directed.push_back(mk_row(2'd3, 5, 5, 170, 85, 1, 1, bsge_pkg::ST_BAD));
		directed.push_back(mk_row(bsge_pkg::REQ_AVAIL, 0, 0, 255, 0, 0, 1, bsge_pkg::ST_ACCEPT));
		directed.push_back(mk_row(bsge_pkg::REQ_AVAIL, 0, 1, 10, 255, 1, 1, bsge_pkg::ST_ACCEPT));
		directed.push_back(mk_row(bsge_pkg::REQ_ENTRY, 1, 1, 2, 8, 0, 1, bsge_pkg::ST_ACCEPT));
		directed.push_back(mk_row(bsge_pkg::REQ_ELEM, 1, 1, 7, 0, 1, 1, bsge_pkg::ST_OVER));
		directed.push_back(mk_row(bsge_pkg::REQ_ELEM, 1, 1, 4, 0, 0, 1, bsge_pkg::ST_ACCEPT));
		directed.push_back(mk_row(bsge_pkg::REQ_ELEM, 1, 0, 0, 0, 1));
		directed.push_back(mk_row(bsge_pkg::REQ_ENTRY, 2, 0, 0, 200, 0, 1, bsge_pkg::ST_ACCEPT));
		directed.push_back(mk_row(bsge_pkg::REQ_AVAIL, 0, 0, 5, 0, 0, 1, bsge_pkg::ST_ACCEPT));
		directed.push_back(mk_row(bsge_pkg::REQ_ELEM, 2, 0, 6, 0, 1, 1, bsge_pkg::ST_UNAVAIL));
		directed.push_back(mk_row(bsge_pkg::REQ_ELEM, 2, 0, 5, 0, 1));
		directed.push_back(mk_row(bsge_pkg::REQ_ELEM, 7, 7, 0, 0, 1));
		foreach (directed[i]) send_item(directed[i]);
		drain();

		write_cfg(bsge_pkg::CFG_THREADS, 4'd3);
		write_cfg(bsge_pkg::CFG_RESOURCES, 4'd2);
		send_item(mk_row(bsge_pkg::REQ_ENTRY, 5, 0, 1, 1, 0, 1, bsge_pkg::ST_BAD));
		send_item(mk_row(bsge_pkg::REQ_AVAIL, 0, 6, 1, 0, 0, 1, bsge_pkg::ST_BAD));
		send_item(mk_row(bsge_pkg::REQ_ELEM, 6, 0, 0, 0, 1, 1, bsge_pkg::ST_OVER));
		random_phase(90);
		drain();

		write_cfg(bsge_pkg::CFG_THREADS, 4'd0);
		write_cfg(bsge_pkg::CFG_RESOURCES, 4'd15);
		random_phase(60);
		drain();

		write_cfg(bsge_pkg::CFG_THREADS, 4'd15);
		write_cfg(bsge_pkg::CFG_RESOURCES, 4'd0);
		random_phase(80);
		drain();

		write_cfg(bsge_pkg::CFG_THREADS, 4'd8);
		write_cfg(bsge_pkg::CFG_RESOURCES, 4'd8);
		random_phase(90);
		drain();

		if (errors == 0 && pending_res.size() == 0) begin
			$display("banker_safe_grant_engine_tb: PASS");
		end else begin
			$display("banker_safe_grant_engine_tb: FAIL");
		end
		$finish;
	end
endmodule
